// File: sv/duty_ratio_search_assert.svh
// Assertion macros for the duty ratio search block
`ifndef DUTY_RATIO_SEARCH_ASSERT_SVH
`define DUTY_RATIO_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
`define DRS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("duty ratio search: check failed");
`define DRS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("duty ratio search: check failed");
`else
`define DRS_ASSERT_NOW(lbl, ante, cons)
`define DRS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: sv/drs_pkg.sv
// Shared constants and types for the duty ratio search block
package drs_pkg;
   localparam int FreqBits  = 20;
   localparam int CountBits = 8;
   localparam int ProdBits  = FreqBits + CountBits;
   localparam int CntBits   = $clog2(FreqBits);
   localparam int IdxBits   = $clog2(CountBits);

   localparam logic [0:0] CsrStockKhz  = 1'b0;
   localparam logic [0:0] CsrMaxPeriod = 1'b1;

   localparam logic [FreqBits-1:0]  StockReset  = FreqBits'(200000);
   localparam logic [CountBits-1:0] PeriodReset = {CountBits{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_DIV1,
      ST_MUL2,
      ST_DIV2,
      ST_CMP,
      ST_DONE
   } state_type;
endpackage

// File: sv/duty_ratio_search.sv
// Duty ratio search: bit-serial scan of period lengths for the closest clock
// The result strobe rsp_valid follows the search; a zero stock_khz or max_period skips
// straight to it. busy is high up to and including the strobe.
// A new request is accepted only while idle. Each trial runs two 8-step
// shift-add multiplies, an 8-step and a 20-step restoring division, and a compare.
// Synchronous active-high reset: idle, stock_khz = 200000, max_period = 255.
`include "duty_ratio_search_assert.svh"
module duty_ratio_search (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [drs_pkg::FreqBits-1:0]  req_target_khz,
   output logic                          rsp_valid,
   output logic [drs_pkg::FreqBits-1:0]  rsp_achieved_khz,
   output logic [drs_pkg::CountBits-1:0] rsp_on_count,
   output logic [drs_pkg::CountBits-1:0] rsp_off_count,
   input  logic                          csr_we,
   input  logic [0:0]                    csr_index,
   input  logic [drs_pkg::FreqBits-1:0]  csr_wdata
);
   import drs_pkg::*;

   state_type             state_ff, state_in;
   logic [FreqBits-1:0]   stock_ff;
   logic [CountBits-1:0]  period_ff;
   logic [FreqBits-1:0]   tgt_ff, tgt_in;
   logic [CountBits-1:0]  len_ff, len_in;
   logic [CntBits-1:0]    cnt_ff, cnt_in;
   logic [ProdBits-1:0]   acc_ff, acc_in;
   logic [CountBits-1:0]  off_ff, off_in;
   logic [FreqBits-1:0]   best_freq_ff, best_freq_in;
   logic [CountBits-1:0]  best_on_ff, best_on_in;
   logic [CountBits-1:0]  best_off_ff, best_off_in;
   logic [FreqBits-1:0]   best_dist_ff, best_dist_in;

   logic                  accept;
   logic [FreqBits:0]     d1_trial;
   logic [FreqBits:0]     d1_diff;
   logic                  d1_q;
   logic [CountBits:0]    d2_trial;
   logic [CountBits:0]    d2_diff;
   logic                  d2_q;
   logic [FreqBits-1:0]   freq;
   logic [FreqBits-1:0]   cand_dist;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         stock_ff  <= StockReset;
         period_ff <= PeriodReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrStockKhz:  stock_ff  <= csr_wdata;
            CsrMaxPeriod: period_ff <= csr_wdata[CountBits-1:0];
            default: ;
         endcase
      end
   end

   // restoring division steps: {rem, numerator bits} shifted one bit a cycle
   assign d1_trial = {acc_ff[ProdBits-1:CountBits], acc_ff[CountBits-1]};
   assign d1_diff  = d1_trial - {1'b0, stock_ff};
   assign d1_q     = (d1_trial >= {1'b0, stock_ff});
   assign d2_trial = {acc_ff[ProdBits-1:FreqBits], acc_ff[FreqBits-1]};
   assign d2_diff  = d2_trial - {1'b0, len_ff};
   assign d2_q     = (d2_trial >= {1'b0, len_ff});

   assign freq      = acc_ff[FreqBits-1:0];
   assign cand_dist = (freq >= tgt_ff) ? (freq - tgt_ff) : (tgt_ff - freq);

   always_comb begin
      state_in     = state_ff;
      tgt_in       = tgt_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      off_in       = off_ff;
      best_freq_in = best_freq_ff;
      best_on_in   = best_on_ff;
      best_off_in  = best_off_ff;
      best_dist_in = best_dist_ff;
      rsp_valid    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               tgt_in       = (req_target_khz > stock_ff) ? stock_ff : req_target_khz;
               best_freq_in = stock_ff;
               best_on_in   = '0;
               best_off_in  = CountBits'(1);
               best_dist_in = stock_ff - tgt_in;
               len_in       = period_ff;
               acc_in       = '0;
               cnt_in       = CntBits'(CountBits - 1);
               if ((stock_ff == '0) || (period_ff == '0)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_MUL1;
               end
            end
         end
         ST_MUL1: begin
            // target * len, multiplier bits MSB first
            acc_in = (acc_ff << 1) +
                     (len_ff[cnt_ff[IdxBits-1:0]] ? ProdBits'(tgt_ff) : '0);
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               cnt_in   = CntBits'(CountBits - 1);
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            acc_in = {(d1_q ? d1_diff[FreqBits-1:0] : d1_trial[FreqBits-1:0]),
                      acc_ff[CountBits-2:0], d1_q};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               off_in   = acc_in[CountBits-1:0];
               acc_in   = '0;
               cnt_in   = CntBits'(CountBits - 1);
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            acc_in = (acc_ff << 1) +
                     (off_ff[cnt_ff[IdxBits-1:0]] ? ProdBits'(stock_ff) : '0);
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               cnt_in   = CntBits'(FreqBits - 1);
               state_in = ST_DIV2;
            end
         end
         ST_DIV2: begin
            // quotient fits FreqBits since off never exceeds len
            acc_in = {(d2_q ? d2_diff[CountBits-1:0] : d2_trial[CountBits-1:0]),
                      acc_ff[FreqBits-2:0], d2_q};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            // ties go to the shorter length, tried later
            if (cand_dist <= best_dist_ff) begin
               best_freq_in = freq;
               best_on_in   = len_ff - off_ff;
               best_off_in  = off_ff;
               best_dist_in = cand_dist;
            end
            len_in = len_ff - 1'b1;
            acc_in = '0;
            cnt_in = CntBits'(CountBits - 1);
            if (len_ff == CountBits'(1)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL1;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff       <= tgt_in;
      len_ff       <= len_in;
      cnt_ff       <= cnt_in;
      acc_ff       <= acc_in;
      off_ff       <= off_in;
      best_freq_ff <= best_freq_in;
      best_on_ff   <= best_on_in;
      best_off_ff  <= best_off_in;
      best_dist_ff <= best_dist_in;
   end

   assign rsp_achieved_khz = best_freq_ff;
   assign rsp_on_count     = best_on_ff;
   assign rsp_off_count    = best_off_ff;

   `DRS_ASSERT_NEXT(a_accept_busy, accept, busy)
   `DRS_ASSERT_NEXT(a_rsp_then_idle, rsp_valid, !busy && !rsp_valid)
   `DRS_ASSERT_NEXT(a_cmp_next, state_ff == ST_CMP, state_ff == ST_MUL1 || state_ff == ST_DONE)
   `DRS_ASSERT_NOW(a_rsp_busy, rsp_valid, busy)
endmodule

// File: tb/testbench.sv
// Self-checking testbench for the duty ratio search block
module testbench;
   import drs_pkg::*;

   class ratio_scoreboard;
      typedef struct {
         logic [FreqBits-1:0]  achieved_khz;
         logic [CountBits-1:0] on_count;
         logic [CountBits-1:0] off_count;
      } ratio_type;

      logic [FreqBits-1:0]  stock_khz;
      logic [CountBits-1:0] max_period;
      ratio_type            pending[$];
      int unsigned          errors;

      function new();
         stock_khz  = StockReset;
         max_period = PeriodReset;
         errors     = 0;
      endfunction

      // Works out the chosen ratio for an accepted request under the current settings
      function void note_request(logic [FreqBits-1:0] target_khz);
         longint unsigned stock, tgt, best, best_on, best_off, len, off, on, freq;
         longint unsigned d_new, d_best;
         ratio_type r;
         stock    = stock_khz;
         tgt      = target_khz;
         if (tgt > stock) tgt = stock;
         best     = stock;
         best_on  = 0;
         best_off = 1;
         if (stock != 0) begin
            for (len = max_period; len > 0; len--) begin
               off    = ((tgt * len) / stock) & 64'hff;
               on     = (len - off) & 64'hff;
               freq   = (stock * off) / len;
               d_new  = (freq >= tgt) ? freq - tgt : tgt - freq;
               d_best = (best >= tgt) ? best - tgt : tgt - best;
               // ties go to the shorter period, tried later
               if (d_new <= d_best) begin
                  best     = freq;
                  best_on  = on;
                  best_off = off;
               end
            end
         end
         r.achieved_khz = best[FreqBits-1:0];
         r.on_count     = best_on[CountBits-1:0];
         r.off_count    = best_off[CountBits-1:0];
         pending.push_back(r);
      endfunction

      function void check_result(logic [FreqBits-1:0] achieved_khz,
                                 logic [CountBits-1:0] on_count,
                                 logic [CountBits-1:0] off_count);
         ratio_type r;
         if (pending.size() == 0) begin
            $error("result with no request outstanding: achieved_khz %0d", achieved_khz);
            errors++;
            return;
         end
         r = pending.pop_front();
         if (achieved_khz !== r.achieved_khz) begin
            $error("achieved_khz: expected %0d, actual %0d", r.achieved_khz, achieved_khz);
            errors++;
         end
         if (on_count !== r.on_count) begin
            $error("on_count: expected %0d, actual %0d", r.on_count, on_count);
            errors++;
         end
         if (off_count !== r.off_count) begin
            $error("off_count: expected %0d, actual %0d", r.off_count, off_count);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [FreqBits-1:0]  req_target_khz = '0;
   logic                 rsp_valid;
   logic [FreqBits-1:0]  rsp_achieved_khz;
   logic [CountBits-1:0] rsp_on_count;
   logic [CountBits-1:0] rsp_off_count;
   logic                 csr_we = 1'b0;
   logic [0:0]           csr_index = CsrStockKhz;
   logic [FreqBits-1:0]  csr_wdata = '0;

   ratio_scoreboard sb = new();

   duty_ratio_search dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_target_khz   (req_target_khz),
      .rsp_valid        (rsp_valid),
      .rsp_achieved_khz (rsp_achieved_khz),
      .rsp_on_count     (rsp_on_count),
      .rsp_off_count    (rsp_off_count),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_achieved_khz, rsp_on_count, rsp_off_count);
   end

   // start stays high after acceptance; an idle gap in the next call or a register write lowers it
   task automatic send_request(input logic [FreqBits-1:0] target, input bit allow_idle);
      int unsigned gap;
      gap = 0;
      if (allow_idle && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 12);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         if ($urandom_range(0, 3) == 0) begin
            do @(posedge clock); while (busy);
         end
      end
      start          <= 1'b1;
      req_target_khz <= target;
      do @(posedge clock); while (busy);
      sb.note_request(target);
   endtask

   task automatic write_reg(input logic [0:0] index, input logic [FreqBits-1:0] value);
      start <= 1'b0;
      while (sb.pending.size() != 0 || busy) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (index)
         CsrStockKhz:  sb.stock_khz  = value;
         CsrMaxPeriod: sb.max_period = value[CountBits-1:0];
         default: ;
      endcase
   endtask

   initial begin
      logic [FreqBits-1:0]  stock, target;
      logic [CountBits-1:0] period;
      int unsigned          n_items;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, longest period
      send_request('0, 1'b1);
      send_request(20'hFFFFF, 1'b1);
      send_request(20'd200000, 1'b1);
      send_request(20'd100000, 1'b1);
      send_request(20'd1, 1'b1);

      write_reg(CsrMaxPeriod, 20'd1);
      send_request('0, 1'b1);
      send_request(20'd199999, 1'b1);
      send_request(20'hFFFFF, 1'b1);

      write_reg(CsrStockKhz, 20'hFFFFF);
      write_reg(CsrMaxPeriod, 20'd255);
      send_request(20'hFFFFF, 1'b1);
      send_request(20'd524287, 1'b1);

      write_reg(CsrStockKhz, 20'd1);
      write_reg(CsrMaxPeriod, 20'd7);
      send_request('0, 1'b1);
      send_request(20'd1, 1'b1);
      send_request(20'hFFFFF, 1'b1);

      // zero stock clock: starting candidate comes straight back
      write_reg(CsrStockKhz, '0);
      send_request(20'd5, 1'b1);
      send_request('0, 1'b1);

      // zero period: nothing searched
      write_reg(CsrStockKhz, 20'd200000);
      write_reg(CsrMaxPeriod, '0);
      send_request(20'd123, 1'b1);
      send_request(20'hFFFFF, 1'b1);

      for (int phase = 0; phase < 10; phase++) begin
         stock   = (phase % 3 == 1) ? 20'($urandom_range(1, 300))
                                    : 20'($urandom_range(1, 20'hFFFFF));
         // long periods are slow, so only one phase uses them
         period  = (phase == 4) ? 8'($urandom_range(200, 255)) : 8'($urandom_range(1, 32));
         n_items = (phase == 4) ? 4 : 11;
         write_reg(CsrStockKhz, stock);
         write_reg(CsrMaxPeriod, {12'($urandom), period});
         for (int i = 0; i < n_items; i++) begin
            case ($urandom_range(0, 3))
               0, 1: target = 20'($urandom_range(0, 20'hFFFFF));
               2:    target = 20'($urandom_range(0, stock));
               default: begin
                  case ($urandom_range(0, 3))
                     0:       target = '0;
                     1:       target = stock;
                     2:       target = stock - 20'd1;
                     default: target = stock + 20'd1;
                  endcase
               end
            endcase
            send_request(target, phase != 9);
         end
      end

      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// File: sim.f
+incdir+sv
sv/drs_pkg.sv
sv/duty_ratio_search.sv
tb/testbench.sv
